// ===== rtl/lfu_cache_table_assert.svh =====
// ----------------------------------------------------------------------------
// lfu_cache_table assertion macros
// Short forms for clocked implication checks on the table's ports.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_TABLE_ASSERT_SVH
`define LFU_CACHE_TABLE_ASSERT_SVH

// same-cycle implication
`define LFU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lfu_cache_table assertion failed");

// next-cycle implication
`define LFU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lfu_cache_table assertion failed");

`endif

// ===== rtl/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants of the LFU cache table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfu_pkg;

	localparam int ENTRIES_DEF     = 16;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam logic [4:0] CAP_RESET = 5'd16;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] read_value;
		logic               evicted;
		logic signed [31:0] evicted_key;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_UPD,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/lfu_cache_table.sv =====
// A hit or insert sweeps the entry memory twice from start to the done strobe
// (one read per cycle); a get miss or a put at zero capacity sweeps it once.
// One item at a time: busy stays high from acceptance through the done cycle,
// and the next beat is taken in the idle state after it. Results are not stallable.
// arst_n clears valid marks, fill level, and sets capacity to 16; no clearing pass.
// ----------------------------------------------------------------------------
// lfu_cache_table
// LFU key/value table with least-recent tie-break, held in one sync memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfu_cache_table #(
	parameter int ENTRIES     = lfu_pkg::ENTRIES_DEF,
	parameter int COUNT_WIDTH = lfu_pkg::COUNT_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  lfu_pkg::req_t cmd,
	output logic          busy,
	output logic          done,
	output lfu_pkg::rsp_t result,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [4:0]    cfg_data
);

	import lfu_pkg::*;

	// index / rank width, fill-count width, compare width, record width
	localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RW   = IW;
	localparam int NW   = $clog2(ENTRIES + 1);
	localparam int CPW  = (NW > 5) ? NW : 5;
	localparam int RECW = 64 + COUNT_WIDTH + RW;

	// record layout: {key, data, count, rank}
	localparam int CNT_LSB = RW;
	localparam int DAT_LSB = RW + COUNT_WIDTH;
	localparam int KEY_LSB = RW + COUNT_WIDTH + 32;

	state_t state_q, state_d;

	req_t                 req_q;
	rsp_t                 rsp_q;
	logic [4:0]           cap_q;
	logic [ENTRIES-1:0]   valid_q;
	logic [NW-1:0]        fill_q;
	logic [NW-1:0]        cnt_q;

	// read issued last cycle; its data is on rdata now
	logic                 pv_q;
	logic [IW-1:0]        pidx_q;

	// scan results
	logic                 match_q;
	logic [IW-1:0]        ms_q;
	logic [RW-1:0]        mrank_q;
	logic [31:0]          mdata_q;
	logic                 vf_q;
	logic [IW-1:0]        vidx_q;
	logic [COUNT_WIDTH-1:0] vcnt_q;
	logic [RW-1:0]        vrank_q;
	logic [31:0]          vkey_q;
	logic                 ff_q;
	logic [IW-1:0]        free_q;

	// update plan
	logic                 ins_q;
	logic                 ev_q;
	logic [IW-1:0]        slot_q;

	// memory ports
	logic                 rd_issue;
	logic [IW-1:0]        rd_addr;
	logic [RECW-1:0]      rdata;
	logic                 we;
	logic [RECW-1:0]      wdata;

	logic [RW-1:0]          r_rank;
	logic [COUNT_WIDTH-1:0] r_cnt;
	logic [31:0]            r_dat;
	logic [31:0]            r_key;

	// decide-step terms
	logic [CPW-1:0] cap_eff;
	logic [CPW-1:0] fill_ext;
	logic           cap_zero;
	logic           d_ev;
	logic           d_ins;
	logic           d_upd;
	logic [IW-1:0]  d_slot;
	logic [ENTRIES-1:0] valid_d;

	assign r_rank = rdata[RW-1:0];
	assign r_cnt  = rdata[CNT_LSB +: COUNT_WIDTH];
	assign r_dat  = rdata[DAT_LSB +: 32];
	assign r_key  = rdata[KEY_LSB +: 32];

	assign cap_eff  = (CPW'(cap_q) > CPW'(ENTRIES)) ? CPW'(ENTRIES) : CPW'(cap_q);
	assign fill_ext = CPW'(fill_q);
	assign cap_zero = (cap_q == 5'd0);
	assign d_ins    = (req_q.opcode == OP_PUT) && !cap_zero && !match_q;
	assign d_ev     = d_ins && (fill_ext >= cap_eff) && vf_q;
	assign d_upd    = match_q && ((req_q.opcode == OP_GET) || !cap_zero);
	// lowest free slot once the victim is gone
	assign d_slot   = (d_ev && !(ff_q && (free_q < vidx_q))) ? vidx_q : free_q;

	// valid marks after the decide step: victim out, new key in
	always_comb begin
		valid_d = valid_q;
		if (d_ev) begin
			valid_d[vidx_q] = 1'b0;
		end
		if (d_ins) begin
			valid_d[d_slot] = 1'b1;
		end
	end

	lfu_mem #(
		.DEPTH (ENTRIES),
		.WIDTH (RECW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (pidx_q),
		.wdata (wdata),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// ---------------- state machine ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == NW'(ENTRIES)) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = (d_upd || d_ins) ? ST_UPD : ST_DONE;
			end
			ST_UPD: begin
				if (cnt_q == NW'(ENTRIES)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy      = (state_q != ST_IDLE);
		done      = (state_q == ST_DONE);
		cfg_ready = (state_q == ST_IDLE);
		rd_issue  = ((state_q == ST_SCAN) || (state_q == ST_UPD)) &&
		            (cnt_q < NW'(ENTRIES));
		rd_addr   = cnt_q[IW-1:0];
	end

	assign result = rsp_q;

	// ---------------- write-back record ----------------
	always_comb begin
		logic [RW-1:0]          nrank;
		logic [COUNT_WIDTH-1:0] ncnt;
		logic [31:0]            ndat;
		nrank = r_rank;
		ncnt  = r_cnt;
		ndat  = r_dat;
		we    = (state_q == ST_UPD) && pv_q && valid_q[pidx_q];
		if (ins_q) begin
			// every survivor ages by one; those older than the victim close the gap
			nrank = r_rank - RW'(ev_q && (r_rank > vrank_q)) + RW'(1);
		end else if (pidx_q == ms_q) begin
			ncnt  = (&r_cnt) ? r_cnt : r_cnt + COUNT_WIDTH'(1);
			nrank = '0;
			if (req_q.opcode == OP_PUT) begin
				ndat = req_q.value;
			end
		end else if (r_rank < mrank_q) begin
			nrank = r_rank + RW'(1);
		end
		wdata = {r_key, ndat, ncnt, nrank};
		if (ins_q && (pidx_q == slot_q)) begin
			wdata = {req_q.key, req_q.value, COUNT_WIDTH'(1), RW'(0)};
		end
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cap_q     <= CAP_RESET;
			valid_q   <= '0;
			fill_q    <= '0;
			cnt_q     <= '0;
			pv_q      <= 1'b0;
			match_q   <= 1'b0;
			vf_q      <= 1'b0;
			ff_q      <= 1'b0;
			ins_q     <= 1'b0;
			ev_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			pv_q    <= rd_issue;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (rd_issue) begin
				cnt_q <= cnt_q + NW'(1);
			end
			if (state_q == ST_IDLE) begin
				cnt_q   <= '0;
				match_q <= 1'b0;
				vf_q    <= 1'b0;
				ff_q    <= 1'b0;
			end
			if (state_q == ST_SCAN && pv_q) begin
				if (valid_q[pidx_q]) begin
					if (r_key == $unsigned(req_q.key)) begin
						match_q <= 1'b1;
					end
					if (!vf_q || (r_cnt < vcnt_q) || ((r_cnt == vcnt_q) && (r_rank > vrank_q))) begin
						vf_q <= 1'b1;
					end
				end else if (!ff_q) begin
					ff_q <= 1'b1;
				end
			end
			if (state_q == ST_DECIDE) begin
				cnt_q     <= '0;
				ins_q     <= d_ins;
				ev_q      <= d_ev;
				valid_q   <= valid_d;
				if (d_ins && !d_ev) begin
					fill_q <= fill_q + NW'(1);
				end
			end
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		pidx_q <= rd_addr;
		if (state_q == ST_IDLE && start) begin
			req_q <= cmd;
		end
		if (state_q == ST_SCAN && pv_q && valid_q[pidx_q]) begin
			if (r_key == $unsigned(req_q.key)) begin
				ms_q    <= pidx_q;
				mrank_q <= r_rank;
				mdata_q <= r_dat;
			end
			if (!vf_q || (r_cnt < vcnt_q) || ((r_cnt == vcnt_q) && (r_rank > vrank_q))) begin
				vidx_q  <= pidx_q;
				vcnt_q  <= r_cnt;
				vrank_q <= r_rank;
				vkey_q  <= r_key;
			end
		end
		if (state_q == ST_SCAN && pv_q && !valid_q[pidx_q] && !ff_q) begin
			free_q <= pidx_q;
		end
		if (state_q == ST_DECIDE) begin
			slot_q          <= d_slot;
			rsp_q.hit       <= match_q;
			rsp_q.evicted   <= d_ev;
			rsp_q.evicted_key <= d_ev ? vkey_q : 32'd0;
			if (req_q.opcode == OP_GET) begin
				rsp_q.read_value <= match_q ? mdata_q : 32'hFFFF_FFFF;
			end else begin
				rsp_q.read_value <= 32'd0;
			end
		end
	end

endmodule

// ===== rtl/lfu_mem.sv =====
// ----------------------------------------------------------------------------
// lfu_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfu_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 84
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/lfu_chk.sv =====
// ----------------------------------------------------------------------------
// lfu_chk
// Port-level checks on the LFU cache table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "lfu_cache_table_assert.svh"

module lfu_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input lfu_pkg::rsp_t result
);

	import lfu_pkg::*;

	`LFU_ASSERT_NXT(a_done_single, done, !done)
	`LFU_ASSERT_NXT(a_start_busy, start && !busy, busy)
	`LFU_ASSERT_NOW(a_done_busy, done, busy)
	`LFU_ASSERT_NOW(a_evk_zero, done && !result.evicted, result.evicted_key == 32'd0)
	`LFU_ASSERT_NOW(a_ev_miss, done && result.evicted, !result.hit)

endmodule

bind lfu_cache_table lfu_chk u_lfu_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ===== verif/lfu_cache_table_test.sv =====
// ----------------------------------------------------------------------------
// lfu_cache_table_test
// Self-checking bench for the LFU table: a directed table of commands, then
// random get/put traffic over a small key pool, every result compared with a
// behavioral LFU/LRU model. Capacity is changed between phases while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfu_cache_table_test;
	import lfu_pkg::*;

	localparam int NENT    = ENTRIES_DEF;
	localparam int CMAX    = (1 << COUNT_WIDTH_DEF) - 1;
	localparam int WDOG    = 2000;
	localparam int SETTLE  = 2 * NENT + 10;

	logic       clk;
	logic       arst_n;
	logic       start;
	req_t       cmd;
	logic       busy;
	logic       done;
	rsp_t       result;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [4:0] cfg_data;

	lfu_cache_table dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .busy(busy),
		.done(done), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// model state
	bit          m_valid [NENT];
	logic [31:0] m_key   [NENT];
	logic [31:0] m_data  [NENT];
	int          m_cnt   [NENT];
	int          m_rank  [NENT];
	int          m_fill;
	int          m_cap;

	rsp_t pending_rsp[$];
	int   errors;
	int   idle_cycles;
	bit   calm;           // no idling stretch

	// directed rows: expected value checked only where chk is set
	typedef struct {
		req_t r;
		bit   chk;
		rsp_t e;
	} row_t;

	function automatic int lookup(logic [31:0] k);
		for (int i = 0; i < NENT; i++)
			if (m_valid[i] && m_key[i] == k)
				return i;
		return -1;
	endfunction

	function automatic void promote(int s);
		int old;
		old = m_rank[s];
		for (int i = 0; i < NENT; i++)
			if (m_valid[i] && i != s && m_rank[i] < old)
				m_rank[i]++;
		m_rank[s] = 0;
	endfunction

	function automatic void touch(int s);
		if (m_cnt[s] < CMAX)
			m_cnt[s]++;
		promote(s);
	endfunction

	// compute the response of one access and update the model
	function automatic rsp_t access(req_t r);
		rsp_t o;
		int   s, v, cap, rk, f;
		o   = '0;
		cap = (m_cap > NENT) ? NENT : m_cap;
		s   = lookup(r.key);
		o.hit = (s >= 0);
		if (r.opcode == OP_GET) begin
			if (s >= 0) begin
				o.read_value = m_data[s];
				touch(s);
			end else begin
				o.read_value = -1;
			end
		end else if (cap != 0) begin
			if (s >= 0) begin
				m_data[s] = r.value;
				touch(s);
			end else begin
				if (m_fill >= cap) begin
					v = -1;
					for (int i = 0; i < NENT; i++)
						if (m_valid[i] && (v < 0 || m_cnt[i] < m_cnt[v] ||
						    (m_cnt[i] == m_cnt[v] && m_rank[i] > m_rank[v])))
							v = i;
					if (v >= 0) begin
						rk = m_rank[v];
						m_valid[v] = 1'b0;
						m_fill--;
						for (int i = 0; i < NENT; i++)
							if (m_valid[i] && m_rank[i] > rk)
								m_rank[i]--;
						o.evicted     = 1'b1;
						o.evicted_key = m_key[v];
					end
				end
				f = -1;
				for (int i = 0; i < NENT; i++)
					if (!m_valid[i] && f < 0)
						f = i;
				if (f >= 0) begin
					for (int j = 0; j < NENT; j++)
						if (m_valid[j])
							m_rank[j]++;
					m_valid[f] = 1'b1;
					m_key[f]   = r.key;
					m_data[f]  = r.value;
					m_cnt[f]   = 1;
					m_rank[f]  = 0;
					m_fill++;
				end
			end
		end
		return o;
	endfunction

	// result checker: results cannot be stalled, sample at each edge
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n) begin
			if (done) begin
				if (pending_rsp.size() == 0) begin
					$error("unexpected result beat");
					errors++;
				end else begin
					e = pending_rsp.pop_front();
					if (result.hit !== e.hit) begin
						$error("hit exp %0d got %0d", e.hit, result.hit);
						errors++;
					end
					if (result.read_value !== e.read_value) begin
						$error("read_value exp %0h got %0h", e.read_value,
							result.read_value);
						errors++;
					end
					if (result.evicted !== e.evicted) begin
						$error("evicted exp %0d got %0d", e.evicted, result.evicted);
						errors++;
					end
					if (result.evicted_key !== e.evicted_key) begin
						$error("evicted_key exp %0h got %0h", e.evicted_key,
							result.evicted_key);
						errors++;
					end
				end
			end
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WDOG) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// issue one command beat; directed rows carry a typed-in expectation
	// start stays high after the beat until the next idle cycle or drain
	task automatic send(req_t r, bit chk, rsp_t e);
		rsp_t p;
		while (!calm && $urandom_range(99) < 29) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		p = access(r);
		if (chk && p !== e) begin
			$error("directed row disagrees with model: exp %0h model %0h", e, p);
			errors++;
		end
		pending_rsp.push_back(p);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_capacity(int c);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= c[4:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		m_cap = c;
	endtask

	function automatic req_t rq(logic op, logic [31:0] k, logic [31:0] v);
		req_t r;
		r.opcode = op;
		r.key    = k;
		r.value  = v;
		return r;
	endfunction

	function automatic rsp_t rs(logic h, logic [31:0] rv, logic ev, logic [31:0] ek);
		rsp_t o;
		o.hit = h; o.read_value = rv; o.evicted = ev; o.evicted_key = ek;
		return o;
	endfunction

	// random access biased toward a small key pool so hits and evictions occur
	task automatic random_phase(int n, int pool);
		req_t        r;
		logic [31:0] k;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 85)
				k = 32'h8000_0000 ^ $urandom_range(pool - 1);
			else
				k = $urandom;
			r = rq(1'($urandom_range(1)), k, $urandom);
			send(r, 1'b0, '0);
			if (i == n / 2)
				drain();      // sender holds until all results are in
		end
	endtask

	row_t rows[$];

	initial begin
		errors = 0; idle_cycles = 0; calm = 1'b0;
		arst_n = 1'b0; start = 1'b0; cmd = '0;
		cfg_valid = 1'b0; cfg_data = '0;
		for (int i = 0; i < NENT; i++) begin
			m_valid[i] = 1'b0; m_key[i] = '0; m_data[i] = '0; m_cnt[i] = 0;
			m_rank[i] = 0;
		end
		m_fill = 0; m_cap = CAP_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		rows.push_back('{rq(OP_GET, 32'h0, 32'h5), 1'b1,
			rs(1'b0, 32'hFFFF_FFFF, 1'b0, 32'd0)});
		rows.push_back('{rq(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF), 1'b1,
			rs(1'b0, 32'd0, 1'b0, 32'd0)});
		rows.push_back('{rq(OP_GET, 32'h8000_0000, 32'h0), 1'b1,
			rs(1'b1, 32'h7FFF_FFFF, 1'b0, 32'd0)});
		rows.push_back('{rq(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000), 1'b1,
			rs(1'b0, 32'd0, 1'b0, 32'd0)});
		rows.push_back('{rq(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1,
			rs(1'b0, 32'd0, 1'b0, 32'd0)});
		rows.push_back('{rq(OP_PUT, 32'h7FFF_FFFF, 32'h1234_5678), 1'b1,
			rs(1'b1, 32'd0, 1'b0, 32'd0)});
		rows.push_back('{rq(OP_GET, 32'hFFFF_FFFF, 32'h0), 1'b0, '0});
		for (int i = 0; i < 15; i++)
			rows.push_back('{rq(OP_PUT, i + 1, ~i), 1'b0, '0});   // overflow, evict
		foreach (rows[i])
			send(rows[i].r, rows[i].chk, rows[i].e);

		// capacity extremes and shrink below fill
		set_capacity(1);
		send(rq(OP_PUT, 32'h55, 32'h1), 1'b0, '0);
		send(rq(OP_PUT, 32'h66, 32'h2), 1'b0, '0);
		set_capacity(0);
		send(rq(OP_PUT, 32'h77, 32'h3), 1'b0, '0);
		send(rq(OP_PUT, 32'h66, 32'h3), 1'b0, '0);
		send(rq(OP_GET, 32'h66, 32'h0), 1'b0, '0);
		set_capacity(31);
		// saturation is out of reach in a short run: count rises far enough
		random_phase(400, 24);
		set_capacity(4);
		calm = 1'b1;
		random_phase(300, 8);
		calm = 1'b0;
		set_capacity(0);
		random_phase(100, 8);
		set_capacity(16);
		random_phase(400, 40);
		set_capacity(7);
		random_phase(300, 12);
		set_capacity(2);
		random_phase(150, 4);

		drain();
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
